@@ hdl/drive_episode_detector_macros.svh @@
// Assertion helpers for the episode detector
`ifndef DRIVE_EPISODE_DETECTOR_MACROS_SVH
`define DRIVE_EPISODE_DETECTOR_MACROS_SVH

// same-cycle implication
`define DED_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DED_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/ded_pkg.sv @@
package ded_pkg;

    localparam int EPOCH_W    = 48;
    localparam int SIG_W      = 16;
    localparam int CNT_W      = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] REG_ACT_SPEED_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACT_TURN_MIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLR_SPEED_MAX = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CLR_TURN_MAX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_GAP       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ACT_HOLD      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CLR_HOLD      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DURATION  = 3'd7;

    localparam logic [14:0] RST_ACT_SPEED_MIN = 15'd3072;
    localparam logic [14:0] RST_ACT_TURN_MIN  = 15'd768;
    localparam logic [14:0] RST_CLR_SPEED_MAX = 15'd1280;
    localparam logic [14:0] RST_CLR_TURN_MAX  = 15'd256;
    localparam logic [15:0] RST_MAX_GAP       = 16'd250;
    localparam logic [15:0] RST_ACT_HOLD      = 16'd500;
    localparam logic [15:0] RST_CLR_HOLD      = 16'd1000;
    localparam logic [19:0] RST_MAX_DURATION  = 20'd12000;

    localparam logic [19:0] KEEP_SPACING_MS = 20'd100;

    localparam logic [1:0] REASON_COMPLETE  = 2'd0;
    localparam logic [1:0] REASON_TRUNCATED = 2'd1;
    localparam logic [1:0] REASON_GAP       = 2'd2;

    typedef struct packed {
        logic [14:0] activate_speed_min;
        logic [14:0] activate_turn_min;
        logic [14:0] clear_speed_max;
        logic [14:0] clear_turn_max;
        logic [15:0] max_gap_ms;
        logic [15:0] activation_hold_ms;
        logic [15:0] clear_hold_ms;
        logic [19:0] max_duration_ms;
    } cfg_t;

    typedef struct packed {
        logic [EPOCH_W-1:0]      time_ms;
        logic signed [SIG_W-1:0] speed;
        logic signed [SIG_W-1:0] turn;
        logic                    all_finite;
    } frame_t;

    typedef struct packed {
        logic               sample_kept;
        logic [CNT_W-1:0]   sample_index;
        logic               episode_open;
        logic               episode_done;
        logic [1:0]         end_reason;
        logic [EPOCH_W-1:0] episode_start_ms;
        logic [EPOCH_W-1:0] episode_end_ms;
        logic [CNT_W-1:0]   episode_samples;
    } result_t;

    typedef struct packed {
        logic               have_last_time;
        logic [EPOCH_W-1:0] last_time;
        logic               activation_pending;
        logic [EPOCH_W-1:0] activation_time;
        logic               clear_pending;
        logic [EPOCH_W-1:0] clear_time;
        logic               suppressed_flag;
        logic               episode_active;
        logic [EPOCH_W-1:0] episode_start;
        logic [EPOCH_W-1:0] episode_last;
        logic               keep_pending;
        logic [EPOCH_W-1:0] keep_time;
        logic [CNT_W-1:0]   kept_count;
    } state_t;

endpackage

@@ hdl/ded_if.sv @@
interface ded_frame_if import ded_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic [EPOCH_W-1:0]      time_ms;
    logic signed [SIG_W-1:0] speed;
    logic signed [SIG_W-1:0] turn;
    logic                    all_finite;

    modport source (output valid, time_ms, speed, turn, all_finite, input ready);
    modport sink   (input valid, time_ms, speed, turn, all_finite, output ready);
endinterface

interface ded_result_if import ded_pkg::*;;
    logic               valid;
    logic               ready;
    logic               sample_kept;
    logic [CNT_W-1:0]   sample_index;
    logic               episode_open;
    logic               episode_done;
    logic [1:0]         end_reason;
    logic [EPOCH_W-1:0] episode_start_ms;
    logic [EPOCH_W-1:0] episode_end_ms;
    logic [CNT_W-1:0]   episode_samples;

    modport source (output valid, sample_kept, sample_index, episode_open, episode_done,
                    end_reason, episode_start_ms, episode_end_ms, episode_samples,
                    input ready);
    modport sink   (input valid, sample_kept, sample_index, episode_open, episode_done,
                    end_reason, episode_start_ms, episode_end_ms, episode_samples,
                    output ready);
endinterface

interface ded_cfg_if import ded_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/ded_cfg_regs.sv @@
module ded_cfg_regs import ded_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    ded_cfg_if.sink cfg,
    output cfg_t    regs
);

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_ACT_SPEED_MIN: regs_next.activate_speed_min = cfg.data[14:0];
                REG_ACT_TURN_MIN:  regs_next.activate_turn_min  = cfg.data[14:0];
                REG_CLR_SPEED_MAX: regs_next.clear_speed_max    = cfg.data[14:0];
                REG_CLR_TURN_MAX:  regs_next.clear_turn_max     = cfg.data[14:0];
                REG_MAX_GAP:       regs_next.max_gap_ms         = cfg.data[15:0];
                REG_ACT_HOLD:      regs_next.activation_hold_ms = cfg.data[15:0];
                REG_CLR_HOLD:      regs_next.clear_hold_ms      = cfg.data[15:0];
                REG_MAX_DURATION:  regs_next.max_duration_ms    = cfg.data[19:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.activate_speed_min <= RST_ACT_SPEED_MIN;
            regs_reg.activate_turn_min  <= RST_ACT_TURN_MIN;
            regs_reg.clear_speed_max    <= RST_CLR_SPEED_MAX;
            regs_reg.clear_turn_max     <= RST_CLR_TURN_MAX;
            regs_reg.max_gap_ms         <= RST_MAX_GAP;
            regs_reg.activation_hold_ms <= RST_ACT_HOLD;
            regs_reg.clear_hold_ms      <= RST_CLR_HOLD;
            regs_reg.max_duration_ms    <= RST_MAX_DURATION;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

@@ hdl/ded_core.sv @@
module ded_core import ded_pkg::*;
#(
    parameter int MAX_SAMPLES = 120
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  frame_t  frame,
    input  cfg_t    cfg,
    output result_t res
);

    state_t st_reg;
    state_t st_next;

    // elapsed time (zero when time ran backwards) at or above a limit
    function automatic logic since_ge(input logic [EPOCH_W-1:0] now,
                                     input logic [EPOCH_W-1:0] past,
                                     input logic [19:0]        lim);
        logic [EPOCH_W:0] d;
        d = {1'b0, now} - {1'b0, past};
        if (d[EPOCH_W])
            return lim == '0;
        return d[EPOCH_W-1:0] >= {{(EPOCH_W-20){1'b0}}, lim};
    endfunction

    always_comb
    begin
        logic [EPOCH_W-1:0] t;
        logic [EPOCH_W:0]   dt;
        logic [14:0]        aturn;
        logic               activating;
        logic               clearing;
        logic               clear_held;
        logic               go;
        logic               maximum;
        logic               show;

        t          = frame.time_ms;
        st_next    = st_reg;
        res        = '0;
        show       = 1'b0;
        go         = 1'b0;
        maximum    = 1'b0;
        clear_held = 1'b0;

        dt = {1'b0, t} - {1'b0, st_reg.last_time};

        // |turn| with -32768 saturating to 32767
        if (!frame.turn[SIG_W-1])
            aturn = frame.turn[14:0];
        else if (frame.turn[14:0] == '0)
            aturn = '1;
        else
            aturn = 15'(-frame.turn);

        activating = !frame.speed[SIG_W-1]
                  && frame.speed[14:0] >= cfg.activate_speed_min
                  && aturn >= cfg.activate_turn_min;
        clearing   = frame.speed[SIG_W-1]
                  || frame.speed[14:0] <= cfg.clear_speed_max
                  || aturn <= cfg.clear_turn_max;

        if (!frame.all_finite || (st_reg.have_last_time
            && (dt[EPOCH_W] || dt[EPOCH_W-1:0] > {{(EPOCH_W-16){1'b0}}, cfg.max_gap_ms})))
        begin
            // abort
            if (st_reg.episode_active)
            begin
                res.episode_done = 1'b1;
                res.end_reason   = REASON_GAP;
                show             = 1'b1;
            end
            st_next.have_last_time     = frame.all_finite;
            st_next.last_time          = frame.all_finite ? t : '0;
            st_next.activation_pending = 1'b0;
            st_next.activation_time    = '0;
            st_next.clear_pending      = 1'b0;
            st_next.clear_time         = '0;
            st_next.suppressed_flag    = 1'b0;
            st_next.episode_active     = 1'b0;
            st_next.keep_pending       = 1'b0;
            st_next.keep_time          = '0;
        end
        else if (st_reg.have_last_time && dt[EPOCH_W-1:0] == '0)
        begin
            // duplicate timestamp
            show = st_reg.episode_active;
        end
        else
        begin
            st_next.have_last_time = 1'b1;
            st_next.last_time      = t;

            if (clearing)
            begin
                if (!st_reg.clear_pending)
                begin
                    st_next.clear_pending = 1'b1;
                    st_next.clear_time    = t;
                end
            end
            else
            begin
                st_next.clear_pending = 1'b0;
                st_next.clear_time    = '0;
            end
            clear_held = st_next.clear_pending
                      && since_ge(t, st_next.clear_time, {4'd0, cfg.clear_hold_ms});

            if (st_reg.suppressed_flag)
            begin
                if (clear_held)
                begin
                    st_next.suppressed_flag    = 1'b0;
                    st_next.activation_pending = 1'b0;
                end
            end
            else
            begin
                go = 1'b1;
                if (!st_reg.episode_active)
                begin
                    if (!activating)
                    begin
                        st_next.activation_pending = 1'b0;
                        go = 1'b0;
                    end
                    else
                    begin
                        if (!st_reg.activation_pending)
                        begin
                            st_next.activation_pending = 1'b1;
                            st_next.activation_time    = t;
                        end
                        if (!since_ge(t, st_next.activation_time,
                                      {4'd0, cfg.activation_hold_ms}))
                        begin
                            go = 1'b0;
                        end
                        else
                        begin
                            st_next.episode_active = 1'b1;
                            st_next.episode_start  = t;
                            st_next.kept_count     = '0;
                            st_next.keep_pending   = 1'b0;
                        end
                    end
                end

                if (go)
                begin
                    st_next.episode_last = t;
                    show = 1'b1;
                    if ((!st_next.keep_pending
                         || since_ge(t, st_next.keep_time, KEEP_SPACING_MS))
                        && st_next.kept_count < CNT_W'(MAX_SAMPLES))
                    begin
                        res.sample_kept      = 1'b1;
                        res.sample_index     = st_next.kept_count;
                        st_next.kept_count   = st_next.kept_count + CNT_W'(1);
                        st_next.keep_pending = 1'b1;
                        st_next.keep_time    = t;
                    end
                    maximum = since_ge(t, st_next.episode_start, cfg.max_duration_ms);
                    if (maximum || clear_held)
                    begin
                        res.episode_done           = 1'b1;
                        res.end_reason             = maximum ? REASON_TRUNCATED
                                                             : REASON_COMPLETE;
                        st_next.episode_active     = 1'b0;
                        st_next.suppressed_flag    = maximum;
                        st_next.activation_pending = 1'b0;
                    end
                end
            end
        end

        res.episode_open = st_next.episode_active;
        if (show)
        begin
            res.episode_start_ms = st_next.episode_start;
            res.episode_end_ms   = st_next.episode_last;
            res.episode_samples  = st_next.kept_count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= '0;
        else if (fire)
            st_reg <= st_next;
    end

endmodule

@@ hdl/drive_episode_detector.sv @@
// Path: a frame is held in the input register, then its result in the result register.
// Throughput: one frame per cycle while result.ready holds; the detector state updates
// as a frame moves into the result register, so consecutive frames need no gap.
// A full result register stalls the input only when the input register is also occupied.
// Reset (rst_n low, async) clears all detector state and restores register defaults.
`include "drive_episode_detector_macros.svh"

module drive_episode_detector import ded_pkg::*;
#(
    parameter int MAX_SAMPLES = 120
)
(
    input  logic          clk,
    input  logic          rst_n,
    ded_frame_if.sink     frame,
    ded_result_if.source  result,
    ded_cfg_if.sink       cfg
);

    cfg_t    regs;
    frame_t  frame_reg;
    logic    in_valid_reg;
    logic    in_valid_next;
    result_t core_res;
    result_t result_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    advance;
    logic    fire;

    ded_cfg_regs u_cfg_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    ded_core #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .frame (frame_reg),
        .cfg   (regs),
        .res   (core_res)
    );

    assign advance     = !out_valid_reg || result.ready;
    assign fire        = in_valid_reg && advance;
    assign frame.ready = !in_valid_reg || advance;

    assign in_valid_next  = (frame.valid && frame.ready) || (in_valid_reg && !fire);
    assign out_valid_next = fire || (out_valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame.valid && frame.ready)
        begin
            frame_reg.time_ms    <= frame.time_ms;
            frame_reg.speed      <= frame.speed;
            frame_reg.turn       <= frame.turn;
            frame_reg.all_finite <= frame.all_finite;
        end
        if (fire)
            result_reg <= core_res;
    end

    assign result.valid            = out_valid_reg;
    assign result.sample_kept      = result_reg.sample_kept;
    assign result.sample_index     = result_reg.sample_index;
    assign result.episode_open     = result_reg.episode_open;
    assign result.episode_done     = result_reg.episode_done;
    assign result.end_reason       = result_reg.end_reason;
    assign result.episode_start_ms = result_reg.episode_start_ms;
    assign result.episode_end_ms   = result_reg.episode_end_ms;
    assign result.episode_samples  = result_reg.episode_samples;

    `DED_ASSERT_SAME(a_done_closes, clk, rst_n,
        out_valid_reg && result_reg.episode_done, !result_reg.episode_open,
        "episode reported done but still open")
    `DED_ASSERT_SAME(a_kept_count, clk, rst_n,
        out_valid_reg && result_reg.sample_kept,
        result_reg.sample_index + CNT_W'(1) == result_reg.episode_samples,
        "kept item index does not match episode count")
    `DED_ASSERT_SAME(a_reason_idle, clk, rst_n,
        out_valid_reg && !result_reg.episode_done, result_reg.end_reason == REASON_COMPLETE,
        "end reason set without episode end")
    `DED_ASSERT_NEXT(a_fire_shows, clk, rst_n, fire, out_valid_reg,
        "processed item did not reach result register")

endmodule

@@ tb/tb_drive_episode_detector.sv @@
module tb_drive_episode_detector import ded_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_KEPT      = 120;
    localparam int SETTLE_CYCLES = 6;
    localparam int RUN_LIMIT_NS  = 10_000_000;

    logic clk;
    logic rst_n;

    ded_frame_if  frame_ch();
    ded_result_if result_ch();
    ded_cfg_if    cfg_ch();

    drive_episode_detector #(.MAX_SAMPLES(MAX_KEPT)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // detector model state and register copy
    cfg_t   ep_cfg;
    state_t ep_st;

    frame_t  frames_to_send[$];
    result_t predicted_reports[$];
    frame_t  frame_on_bus;
    int      reports_owed;
    int      failures;
    int      send_idle_pct;
    int      recv_idle_pct;
    logic [EPOCH_W-1:0] gen_now;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("tb_drive_episode_detector: FAIL");
        $finish;
    end

    function automatic logic [EPOCH_W-1:0] elapsed_ms(logic [EPOCH_W-1:0] later_t,
                                                      logic [EPOCH_W-1:0] earlier_t);
        return (later_t >= earlier_t) ? later_t - earlier_t : '0;
    endfunction

    function automatic void drop_tracking();
        ep_st.have_last_time     = 1'b0;
        ep_st.last_time          = '0;
        ep_st.activation_pending = 1'b0;
        ep_st.activation_time    = '0;
        ep_st.clear_pending      = 1'b0;
        ep_st.clear_time         = '0;
        ep_st.suppressed_flag    = 1'b0;
        ep_st.episode_active     = 1'b0;
        ep_st.keep_pending       = 1'b0;
        ep_st.keep_time          = '0;
    endfunction

    function automatic result_t predict_episode_result(frame_t f);
        result_t            r;
        logic [EPOCH_W-1:0] t;
        int                 spd;
        int                 aturn;
        bit                 show;
        bit                 go;
        bit                 maximum;
        bit                 activating;
        bit                 clearing;
        r     = '0;
        show  = 1'b0;
        t     = f.time_ms;
        spd   = $signed(f.speed);
        aturn = $signed(f.turn);
        if (aturn < 0)
            aturn = -aturn;
        if (aturn > 32767)
            aturn = 32767;

        if (!f.all_finite || (ep_st.have_last_time && (t < ep_st.last_time ||
                (t - ep_st.last_time) > 48'(ep_cfg.max_gap_ms))))
        begin
            if (ep_st.episode_active)
            begin
                r.episode_done = 1'b1;
                r.end_reason   = REASON_GAP;
                show           = 1'b1;
            end
            drop_tracking();
            if (f.all_finite)
            begin
                ep_st.have_last_time = 1'b1;
                ep_st.last_time      = t;
            end
        end
        else if (ep_st.have_last_time && t == ep_st.last_time)
        begin
            // repeated timestamp: frame ignored
            show = ep_st.episode_active;
        end
        else
        begin
            ep_st.have_last_time = 1'b1;
            ep_st.last_time      = t;
            activating = spd >= int'(ep_cfg.activate_speed_min) &&
                         aturn >= int'(ep_cfg.activate_turn_min);
            clearing   = spd <= int'(ep_cfg.clear_speed_max) ||
                         aturn <= int'(ep_cfg.clear_turn_max);
            if (clearing)
            begin
                if (!ep_st.clear_pending)
                begin
                    ep_st.clear_pending = 1'b1;
                    ep_st.clear_time    = t;
                end
            end
            else
            begin
                ep_st.clear_pending = 1'b0;
                ep_st.clear_time    = '0;
            end

            if (ep_st.suppressed_flag)
            begin
                if (ep_st.clear_pending &&
                    elapsed_ms(t, ep_st.clear_time) >= 48'(ep_cfg.clear_hold_ms))
                begin
                    ep_st.suppressed_flag    = 1'b0;
                    ep_st.activation_pending = 1'b0;
                end
            end
            else
            begin
                go = 1'b1;
                if (!ep_st.episode_active)
                begin
                    if (!activating)
                    begin
                        ep_st.activation_pending = 1'b0;
                        go = 1'b0;
                    end
                    else
                    begin
                        if (!ep_st.activation_pending)
                        begin
                            ep_st.activation_pending = 1'b1;
                            ep_st.activation_time    = t;
                        end
                        if (elapsed_ms(t, ep_st.activation_time) <
                            48'(ep_cfg.activation_hold_ms))
                            go = 1'b0;
                        else
                        begin
                            ep_st.episode_active = 1'b1;
                            ep_st.episode_start  = t;
                            ep_st.kept_count     = '0;
                            ep_st.keep_pending   = 1'b0;
                        end
                    end
                end
                if (go)
                begin
                    ep_st.episode_last = t;
                    show = 1'b1;
                    if ((!ep_st.keep_pending ||
                         elapsed_ms(t, ep_st.keep_time) >= 48'(KEEP_SPACING_MS)) &&
                        int'(ep_st.kept_count) < MAX_KEPT)
                    begin
                        r.sample_kept      = 1'b1;
                        r.sample_index     = ep_st.kept_count;
                        ep_st.kept_count   = ep_st.kept_count + 1'b1;
                        ep_st.keep_pending = 1'b1;
                        ep_st.keep_time    = t;
                    end
                    maximum = elapsed_ms(t, ep_st.episode_start) >=
                              48'(ep_cfg.max_duration_ms);
                    if (maximum || (ep_st.clear_pending &&
                        elapsed_ms(t, ep_st.clear_time) >= 48'(ep_cfg.clear_hold_ms)))
                    begin
                        r.episode_done           = 1'b1;
                        r.end_reason             = maximum ? REASON_TRUNCATED
                                                           : REASON_COMPLETE;
                        ep_st.episode_active     = 1'b0;
                        ep_st.suppressed_flag    = maximum;
                        ep_st.activation_pending = 1'b0;
                    end
                end
            end
        end

        r.episode_open = ep_st.episode_active;
        if (show)
        begin
            r.episode_start_ms = ep_st.episode_start;
            r.episode_end_ms   = ep_st.episode_last;
            r.episode_samples  = ep_st.kept_count;
        end
        return r;
    endfunction

    function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] val);
        case (idx)
            REG_ACT_SPEED_MIN: ep_cfg.activate_speed_min = val[14:0];
            REG_ACT_TURN_MIN:  ep_cfg.activate_turn_min  = val[14:0];
            REG_CLR_SPEED_MAX: ep_cfg.clear_speed_max    = val[14:0];
            REG_CLR_TURN_MAX:  ep_cfg.clear_turn_max     = val[14:0];
            REG_MAX_GAP:       ep_cfg.max_gap_ms         = val[15:0];
            REG_ACT_HOLD:      ep_cfg.activation_hold_ms = val[15:0];
            REG_CLR_HOLD:      ep_cfg.clear_hold_ms      = val[15:0];
            REG_MAX_DURATION:  ep_cfg.max_duration_ms    = val[19:0];
            default: ;
        endcase
    endfunction

    task automatic compare_field(string field, logic [EPOCH_W-1:0] got,
                                 logic [EPOCH_W-1:0] want);
        if (got !== want)
        begin
            failures++;
            if (failures <= 10)
                $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                         $realtime, field, want, got);
        end
    endtask

    // frame driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (frame_ch.valid && frame_ch.ready)
                predicted_reports.insert(predicted_reports.size(),
                                         predict_episode_result(frame_on_bus));
            if (!frame_ch.valid || frame_ch.ready)
            begin
                if (frames_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    frame_on_bus         = frames_to_send.pop_front();
                    frame_ch.valid      <= 1'b1;
                    frame_ch.time_ms    <= frame_on_bus.time_ms;
                    frame_ch.speed      <= frame_on_bus.speed;
                    frame_ch.turn       <= frame_on_bus.turn;
                    frame_ch.all_finite <= frame_on_bus.all_finite;
                end
                else
                    frame_ch.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin : result_monitor
        result_t want;
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (predicted_reports.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("%0t: result item with nothing predicted", $realtime);
                end
                else
                begin
                    want = predicted_reports.pop_front();
                    compare_field("sample_kept", EPOCH_W'(result_ch.sample_kept),
                                  EPOCH_W'(want.sample_kept));
                    compare_field("sample_index", EPOCH_W'(result_ch.sample_index),
                                  EPOCH_W'(want.sample_index));
                    compare_field("episode_open", EPOCH_W'(result_ch.episode_open),
                                  EPOCH_W'(want.episode_open));
                    compare_field("episode_done", EPOCH_W'(result_ch.episode_done),
                                  EPOCH_W'(want.episode_done));
                    compare_field("end_reason", EPOCH_W'(result_ch.end_reason),
                                  EPOCH_W'(want.end_reason));
                    compare_field("episode_start_ms", result_ch.episode_start_ms,
                                  want.episode_start_ms);
                    compare_field("episode_end_ms", result_ch.episode_end_ms,
                                  want.episode_end_ms);
                    compare_field("episode_samples", EPOCH_W'(result_ch.episode_samples),
                                  EPOCH_W'(want.episode_samples));
                    reports_owed--;
                end
            end
            result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic push_frame(logic [EPOCH_W-1:0] ep, int spd, int trn, bit fin);
        frame_t f;
        f.time_ms    = ep;
        f.speed      = spd[15:0];
        f.turn       = trn[15:0];
        f.all_finite = fin;
        frames_to_send.insert(frames_to_send.size(), f);
        reports_owed++;
    endtask

    task automatic wait_reports_settled();
        while (reports_owed != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        apply_register(idx, val);
    endtask

    task automatic load_thresholds(int act_spd, int act_trn, int clr_spd, int clr_trn,
                                   int gap, int act_hold, int clr_hold, int max_dur);
        write_reg(REG_ACT_SPEED_MIN, CFG_DATA_W'(act_spd));
        write_reg(REG_ACT_TURN_MIN, CFG_DATA_W'(act_trn));
        write_reg(REG_CLR_SPEED_MAX, CFG_DATA_W'(clr_spd));
        write_reg(REG_CLR_TURN_MAX, CFG_DATA_W'(clr_trn));
        write_reg(REG_MAX_GAP, CFG_DATA_W'(gap));
        write_reg(REG_ACT_HOLD, CFG_DATA_W'(act_hold));
        write_reg(REG_CLR_HOLD, CFG_DATA_W'(clr_hold));
        write_reg(REG_MAX_DURATION, CFG_DATA_W'(max_dur));
    endtask

    function automatic int rand_in(int lo, int hi);
        if (hi <= lo)
            return hi;
        return lo + int'($urandom_range(hi - lo));
    endfunction

    // random sign; full-scale negative magnitude sometimes becomes -32768
    function automatic int signed_mag(int m);
        if ($urandom_range(1))
            return m;
        if (m == 32767 && $urandom_range(1))
            return -32768;
        return -m;
    endfunction

    // runs of activating / clearing / in-between / random frames with occasional disruptions
    task automatic send_random_frames(int count, int run_max, int noisy_pct);
        int produced;
        int run_len;
        int cls;
        int spd;
        int trn;
        bit fin;
        bit dup;
        bit paused;
        produced = 0;
        paused   = 1'b0;
        while (produced < count)
        begin
            cls = $urandom_range(99);
            if (cls < 45)
                run_len = 1 + $urandom_range(run_max - 1);
            else if (cls < 75)
                run_len = 1 + $urandom_range(29);
            else if (cls < 90)
                run_len = 1 + $urandom_range(9);
            else
                run_len = 1 + $urandom_range(7);
            for (int j = 0; j < run_len && produced < count; j++)
            begin
                dup = 1'b0;
                if ($urandom_range(99) < noisy_pct)
                begin
                    case ($urandom_range(3))
                        0: dup = 1'b1;
                        1: gen_now = gen_now + 48'(ep_cfg.max_gap_ms) +
                                     48'(1 + $urandom_range(1000));
                        2: gen_now = gen_now - 48'(1 + $urandom_range(500));
                        default: gen_now = 48'({$urandom, $urandom});
                    endcase
                end
                else if (ep_cfg.max_gap_ms == 0)
                    gen_now = gen_now + 48'(1);
                else
                    gen_now = gen_now +
                              48'(1 + $urandom_range(32'(ep_cfg.max_gap_ms) - 1));

                if (cls < 45)
                begin
                    spd = rand_in(int'(ep_cfg.activate_speed_min), 32767);
                    trn = signed_mag(rand_in(int'(ep_cfg.activate_turn_min), 32767));
                end
                else if (cls < 75)
                begin
                    if ($urandom_range(1))
                    begin
                        spd = rand_in(-32768, int'(ep_cfg.clear_speed_max));
                        trn = $urandom;
                    end
                    else
                    begin
                        spd = $urandom;
                        trn = signed_mag(rand_in(0, int'(ep_cfg.clear_turn_max)));
                    end
                end
                else if (cls < 90)
                begin
                    spd = rand_in(int'(ep_cfg.clear_speed_max) + 1, 32767);
                    trn = signed_mag(rand_in(int'(ep_cfg.clear_turn_max) + 1, 32767));
                end
                else
                begin
                    spd = $urandom;
                    trn = $urandom;
                end
                fin = ($urandom_range(99) >= (noisy_pct + 3) / 4);
                push_frame(gen_now, spd, trn, fin);
                if (!dup)
                    produced++;
                // hold the sender once until the block has drained
                if (!paused && count >= 40 && produced >= count / 2)
                begin
                    paused = 1'b1;
                    wait_reports_settled();
                end
            end
        end
    endtask

    initial
    begin
        rst_n               = 1'b0;
        frame_ch.valid      = 1'b0;
        frame_ch.time_ms    = '0;
        frame_ch.speed      = '0;
        frame_ch.turn       = '0;
        frame_ch.all_finite = 1'b0;
        result_ch.ready     = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = '0;
        cfg_ch.data         = '0;
        reports_owed        = 0;
        failures            = 0;
        gen_now             = '0;
        ep_st               = '0;
        ep_cfg.activate_speed_min = RST_ACT_SPEED_MIN;
        ep_cfg.activate_turn_min  = RST_ACT_TURN_MIN;
        ep_cfg.clear_speed_max    = RST_CLR_SPEED_MAX;
        ep_cfg.clear_turn_max     = RST_CLR_TURN_MAX;
        ep_cfg.max_gap_ms         = RST_MAX_GAP;
        ep_cfg.activation_hold_ms = RST_ACT_HOLD;
        ep_cfg.clear_hold_ms      = RST_CLR_HOLD;
        ep_cfg.max_duration_ms    = RST_MAX_DURATION;
        send_idle_pct = 22;
        recv_idle_pct = 76;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset thresholds: open, repeat, spacing, complete end
        push_frame(48'd0,    32767, -32768, 1'b1);
        push_frame(48'd250,  32767,  32767, 1'b1);
        push_frame(48'd500,   3072,    768, 1'b1);
        push_frame(48'd500,      0,      0, 1'b1);
        push_frame(48'd600,  20000,   -768, 1'b1);
        push_frame(48'd650,  20000,   5000, 1'b1);
        push_frame(48'd900, -32768, -32768, 1'b1);
        push_frame(48'd1150,  1280,   5000, 1'b1);
        push_frame(48'd1400,  5000,    256, 1'b1);
        push_frame(48'd1650,     0,      0, 1'b1);
        push_frame(48'd1900,    -1,     -1, 1'b1);
        // non-finite frame ends an open episode
        push_frame(48'd2000, 32767,  32767, 1'b1);
        push_frame(48'd2250, 32767,  32767, 1'b1);
        push_frame(48'd2500, 32767,  32767, 1'b1);
        push_frame(48'd2600,     0,      0, 1'b0);
        // backwards time ends an open episode
        push_frame(48'd2700, 32767, -32767, 1'b1);
        push_frame(48'd2950, 32767, -32767, 1'b1);
        push_frame(48'd3200, 32767, -32767, 1'b1);
        push_frame(48'd3100, 32767, -32767, 1'b1);
        // gap with no open episode, then timestamp extremes
        push_frame(48'd3351, 32767,  32767, 1'b1);
        push_frame(48'hFFFF_FFFF_FFFF, 32767, 32767, 1'b1);
        push_frame(48'd0, -32768, 32767, 1'b1);
        gen_now = 48'd10_000;
        send_random_frames(350, 110, 12);
        wait_reports_settled();

        // everything at zero, widest gap
        load_thresholds(0, 0, 0, 0, 65535, 0, 0, 0);
        send_random_frames(150, 20, 12);
        wait_reports_settled();

        send_idle_pct = 76;
        recv_idle_pct = 22;
        // everything at full scale
        load_thresholds(32767, 32767, 32767, 32767, 65535, 65535, 65535, 1048575);
        gen_now = 48'({$urandom, $urandom});
        send_random_frames(250, 60, 10);
        wait_reports_settled();

        // long episodes that run into the kept-frame cap
        load_thresholds(3072, 768, 1280, 256, 250, 100, 300, 1048575);
        send_random_frames(250, 200, 1);
        send_random_frames(150, 150, 8);
        wait_reports_settled();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (2)
        begin
            load_thresholds($urandom_range(32767), $urandom_range(32767),
                            $urandom_range(32767), $urandom_range(32767),
                            50 + $urandom_range(950), $urandom_range(2000),
                            $urandom_range(2000), $urandom_range(20000));
            send_random_frames(300, 80, 12);
            wait_reports_settled();
        end

        // zero allowed gap: every forward step aborts
        load_thresholds(3072, 768, 1280, 256, 0, 500, 1000, 12000);
        send_random_frames(60, 10, 12);
        wait_reports_settled();

        if (failures == 0)
            $display("tb_drive_episode_detector: PASS");
        else
            $display("tb_drive_episode_detector: FAIL");
        $finish;
    end

endmodule
